// File: rtl/wmco_pkg.sv
// ---------------------------------------------------------------------------
// wmco_pkg
// Shared types and constants of the windowed minimum clock offset filter.
// ---------------------------------------------------------------------------
package wmco_pkg;

   // built depth of the sample ring
   localparam int RING_DEPTH  = 64;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int RING_SIZE_W = 7;
   localparam int SZ_W        = (CNT_W > RING_SIZE_W) ? CNT_W : RING_SIZE_W;
   localparam int TIME_W      = 64;
   localparam int CSR_IDX_W   = 4;

   localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = RING_SIZE_W'(64);

   // operation codes
   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_CONVERT = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]        operation;
      logic [TIME_W-1:0] remote_time;
      logic [TIME_W-1:0] local_time;
   } req_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] offset_estimate;
      logic [TIME_W-1:0]        spread_estimate;
      logic [TIME_W-1:0]        converted_time;
      logic                     sample_taken;
   } rsp_type;

   // one ring entry
   typedef struct packed {
      logic [TIME_W-1:0] local_time;
      logic [TIME_W-1:0] delta;
   } sample_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

// File: rtl/wmco_ram.sv
// ---------------------------------------------------------------------------
// wmco_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module wmco_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/windowed_min_clock_offset.sv
// ---------------------------------------------------------------------------
// windowed_min_clock_offset
// Minimum-delay clock offset filter over a ring of timestamp samples.
// ---------------------------------------------------------------------------
// One request at a time. An observe that stores a sample writes it to the
// ring RAM and then reads the older samples back, newest first, one RAM read
// per cycle through the single read port, folding each into a running signed
// minimum and maximum of the deltas; the walk ends early at the first sample
// that lies outside the age window. The walk is followed by the estimate
// update state and the result hand-over state, which loads the output
// register and returns to idle, where the next request is taken. Convert,
// clear, an ignored observe and an unknown operation go straight from idle
// to the hand-over state. The result sits in an output register, so the
// next request is taken while the previous result still waits; a second
// result held back by rsp_ready stalls the block in its hand-over state
// until the output register frees. The RAM needs no clearing after reset:
// the fill count keeps the walk inside entries that have been written.
// ---------------------------------------------------------------------------
module windowed_min_clock_offset
   import wmco_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   // register write port
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   // control state
   state_type               state_ff, state_in;
   logic [RING_SIZE_W-1:0]  ring_size_ff, ring_size_in;
   logic [TIME_W-1:0]       window_ff, window_in;
   logic [IDX_W-1:0]        write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic signed [TIME_W-1:0] offset_ff, offset_in;
   logic [TIME_W-1:0]       spread_ff, spread_in;
   logic [IDX_W-1:0]        issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]        issue_left_ff, issue_left_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // working values of the current request
   logic [TIME_W-1:0]        conv_ff, conv_in;
   logic                     taken_ff, taken_in;
   logic [TIME_W-1:0]        head_time_ff, head_time_in;
   logic signed [TIME_W-1:0] lo_ff, lo_in;
   logic signed [TIME_W-1:0] hi_ff, hi_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // ring ram
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   sample_type              ram_wr_data;
   sample_type              ram_rd_data;

   // derived values
   logic [SZ_W-1:0]         size_ext;
   logic [CNT_W-1:0]        cap;
   logic [IDX_W-1:0]        ws_eff;
   logic [CNT_W-1:0]        ws_plus;
   logic [IDX_W-1:0]        ws_next;
   logic [CNT_W-1:0]        fill_clamped;
   logic [CNT_W-1:0]        fill_new;
   logic [TIME_W-1:0]       delta;
   logic [TIME_W-1:0]       conv_sum;
   logic [TIME_W-1:0]       age;
   logic                    stop;

   // step one slot back in the ring, wrapping at the slots in use
   function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] size);
      if (idx == '0) begin
         return IDX_W'(size - CNT_W'(1));
      end
      return idx - IDX_W'(1);
   endfunction

   // slots in use: register value saturated at the built depth
   assign size_ext = SZ_W'(ring_size_ff);
   assign cap      = (size_ext > SZ_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : CNT_W'(size_ext);

   // write position and fill level after this sample
   assign ws_eff       = (CNT_W'(write_slot_ff) >= cap) ? '0 : write_slot_ff;
   assign ws_plus      = CNT_W'(ws_eff) + CNT_W'(1);
   assign ws_next      = (ws_plus == cap) ? '0 : IDX_W'(ws_plus);
   assign fill_clamped = (fill_ff > cap) ? cap : fill_ff;
   assign fill_new     = (fill_clamped < cap) ? fill_clamped + CNT_W'(1) : fill_clamped;

   // local minus remote, wrapping
   assign delta    = req_data.local_time - req_data.remote_time;
   assign conv_sum = req_data.remote_time + TIME_W'(offset_ff);

   // age test of the sample coming out of the ram
   assign age  = head_time_ff - ram_rd_data.local_time;
   assign stop = (window_ff != '0) && (age > window_ff);

   assign ram_wr_data.local_time = req_data.local_time;
   assign ram_wr_data.delta      = delta;

   always_comb begin
      state_in        = state_ff;
      ring_size_in    = ring_size_ff;
      window_in       = window_ff;
      write_slot_in   = write_slot_ff;
      fill_in         = fill_ff;
      offset_in       = offset_ff;
      spread_in       = spread_ff;
      issue_idx_in    = issue_idx_ff;
      issue_left_in   = issue_left_ff;
      pend_in         = 1'b0;
      conv_in         = conv_ff;
      taken_in        = taken_ff;
      head_time_in    = head_time_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      req_ready       = (state_ff == ST_IDLE);

      // the user must write registers only while idle; the block does not enforce it
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RING_SIZE: begin
               // resizing empties the ring
               ring_size_in  = csr_wdata[RING_SIZE_W-1:0];
               write_slot_in = '0;
               fill_in       = '0;
               offset_in     = '0;
               spread_in     = '0;
            end
            CSR_WINDOW: begin
               window_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               conv_in  = '0;
               taken_in = 1'b0;
               state_in = ST_DONE;
               case (req_data.operation)
                  OP_OBSERVE: begin
                     // zero remote time or no capacity: pair ignored
                     if (cap != '0 && req_data.remote_time != '0) begin
                        ram_wr_en       = 1'b1;
                        write_slot_in   = ws_next;
                        fill_in         = fill_new;
                        head_time_in    = req_data.local_time;
                        lo_in           = $signed(delta);
                        hi_in           = $signed(delta);
                        issue_idx_in    = prev_slot(ws_eff, cap);
                        issue_left_in   = fill_new - CNT_W'(1);
                        state_in        = ST_WALK;
                     end
                  end
                  OP_CONVERT: begin
                     // not positive clamps to zero
                     if (conv_sum != '0 && !conv_sum[TIME_W-1]) begin
                        conv_in = conv_sum;
                     end
                  end
                  OP_CLEAR: begin
                     write_slot_in = '0;
                     fill_in       = '0;
                     offset_in     = '0;
                     spread_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (pend_ff && stop) begin
               // first sample outside the window ends the walk
               state_in = ST_FINISH;
            end else begin
               if (pend_ff) begin
                  if ($signed(ram_rd_data.delta) < lo_ff) begin
                     lo_in = $signed(ram_rd_data.delta);
                  end
                  if (hi_ff < $signed(ram_rd_data.delta)) begin
                     hi_in = $signed(ram_rd_data.delta);
                  end
               end
               if (issue_left_ff != '0) begin
                  ram_rd_en     = 1'b1;
                  issue_idx_in  = prev_slot(issue_idx_ff, cap);
                  issue_left_in = issue_left_ff - CNT_W'(1);
                  pend_in       = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            offset_in = lo_ff;
            spread_in = TIME_W'(hi_ff - lo_ff);
            taken_in  = 1'b1;
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            // hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.offset_estimate = offset_ff;
               rsp_data_in.spread_estimate = spread_ff;
               rsp_data_in.converted_time  = conv_ff;
               rsp_data_in.sample_taken    = taken_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ring_size_ff  <= RING_SIZE_RESET;
         window_ff     <= '0;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         offset_ff     <= '0;
         spread_ff     <= '0;
         issue_idx_ff  <= '0;
         issue_left_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ring_size_ff  <= ring_size_in;
         window_ff     <= window_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         offset_ff     <= offset_in;
         spread_ff     <= spread_in;
         issue_idx_ff  <= issue_idx_in;
         issue_left_ff <= issue_left_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      conv_ff         <= conv_in;
      taken_ff        <= taken_in;
      head_time_ff    <= head_time_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // sample ring: local time and delta side by side
   wmco_ram #(
      .WIDTH ($bits(sample_type)),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ws_eff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the fill level never exceeds the built depth
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(RING_DEPTH))
      else $error("fill level above ring depth");

   // with samples held, the write slot lies inside the slots in use
   a_slot_in_range : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) || (CNT_W'(write_slot_ff) < cap))
      else $error("write slot outside ring");

   // ram read data is only awaited during the walk
   a_pend_in_walk : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_WALK))
      else $error("read pending outside walk");

   // the estimate update is followed by the result hand-over state
   a_finish_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (state_ff == ST_DONE))
      else $error("finish not followed by done");

   // a new result only comes out of the done state
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && (!rsp_valid_ff || rsp_ready)) |-> (state_ff == ST_DONE))
      else $error("result loaded outside done");

endmodule
